// ----- hw/rtl/slri_pkg.sv -----
// shared types and constants for the sorted list with insert and remove
package slri_pkg;

	localparam int CAPACITY  = 16;
	localparam int KEY_BITS  = 16;
	localparam int TAG_BITS  = 8;
	localparam int RANK_BITS = 4;
	localparam int CNT_W     = $clog2(CAPACITY + 1);

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_BAD_RANK  = 2'd3;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [TAG_BITS-1:0] tag;
	} entry_t;

	// operation broadcast to every cell
	typedef struct packed {
		logic   ins_en;
		logic   rem_en;
		entry_t ent;
	} cell_cmd_t;

	// per-cell compare results
	typedef struct packed {
		logic ins_ge;
		logic rem_past;
		logic match;
	} cell_flags_t;

endpackage

// ----- hw/rtl/slri_cell.sv -----
// one slot of the sorted chain: compares its key and shifts with its neighbours
module slri_cell
	import slri_pkg::*;
(
	input  logic        clk,
	input  cell_cmd_t   cmd,
	input  logic        occ,
	input  logic        left_ins_ge,
	input  entry_t      left_ent,
	input  entry_t      right_ent,
	output cell_flags_t flags,
	output entry_t      ent,
	output entry_t      ent_nxt
);

	entry_t ent_q;

	always_comb begin
		// at or past the insert point: free slot or a strictly larger key
		flags.ins_ge   = !occ || (ent_q.key > cmd.ent.key);
		// keys are sorted, so cells at or past the first match form a suffix
		flags.rem_past = occ && (ent_q.key >= cmd.ent.key);
		flags.match    = occ && (ent_q.key == cmd.ent.key);
	end

	always_comb begin
		ent_nxt = ent_q;
		if (cmd.ins_en) begin
			if (left_ins_ge) begin
				ent_nxt = left_ent;
			end else if (flags.ins_ge) begin
				ent_nxt = cmd.ent;
			end
		end else if (cmd.rem_en) begin
			if (flags.rem_past) begin
				ent_nxt = right_ent;
			end
		end
	end

	always_ff @(posedge clk) begin
		ent_q <= ent_nxt;
	end

	assign ent = ent_q;

endmodule

// ----- hw/rtl/sorted_list_insert_remove.sv -----
// top level: chain of sorted cells, fill count and registered result
//
// channel | beat holds                               | handshake
// --------+------------------------------------------+-------------------
// in      | opcode, key, tag, rank                   | in_valid / in_stall
// out     | status, entry_count, entry_key/tag/valid | out_valid / out_stall
//
// one beat is taken per cycle while in_stall is low; its result appears in the output register on
// the next cycle. every cell compares its key against the beat in parallel and
// loads from itself, its left or right neighbour or the new entry, so no step iterates.
// in_stall rises only while a result is held and out_stall is high.
// arst_n clears the fill count and the output valid; cell contents need no reset.
module sorted_list_insert_remove
	import slri_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           opcode,
	input  logic [KEY_BITS-1:0]  key,
	input  logic [TAG_BITS-1:0]  tag,
	input  logic [RANK_BITS-1:0] rank,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           status,
	output logic [CNT_W-1:0]     entry_count,
	output logic [KEY_BITS-1:0]  entry_key,
	output logic [TAG_BITS-1:0]  entry_tag,
	output logic                 entry_valid
);

	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_d;
	logic                out_valid_q;
	logic [1:0]          status_q;
	logic [CNT_W-1:0]    count_out_q;
	entry_t              ent_out_q;
	logic                ent_valid_q;

	logic                accept;
	logic                full;
	logic                found;
	logic                rank_ok;
	cell_cmd_t           cmd;
	cell_flags_t         flags   [CAPACITY];
	entry_t              ents    [CAPACITY];
	entry_t              ents_nxt[CAPACITY];
	logic [CAPACITY-1:0] match_vec;
	entry_t              rd_ent;
	logic [1:0]          status_d;
	entry_t              ent_d;
	logic                ent_valid_d;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign found    = |match_vec;

	always_comb begin
		cmd.ent.key = key;
		cmd.ent.tag = tag;
		cmd.ins_en  = accept && (opcode == OP_INSERT) && !full;
		cmd.rem_en  = accept && (opcode == OP_REMOVE) && found;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic   left_ge;
		entry_t left_e;
		entry_t right_e;

		if (i == 0) begin : g_first
			assign left_ge = 1'b0;
			assign left_e  = '0;
		end else begin : g_mid
			assign left_ge = flags[i-1].ins_ge;
			assign left_e  = ents[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_e = '0;
		end else begin : g_inner
			assign right_e = ents[i+1];
		end

		slri_cell u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.occ         (i < int'(count_q)),
			.left_ins_ge (left_ge),
			.left_ent    (left_e),
			.right_ent   (right_e),
			.flags       (flags[i]),
			.ent         (ents[i]),
			.ent_nxt     (ents_nxt[i])
		);

		assign match_vec[i] = flags[i].match;
	end

	always_comb begin
		count_d = count_q;
		if (cmd.ins_en) begin
			count_d = count_q + CNT_W'(1);
		end else if (cmd.rem_en) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	// entry at the requested rank, taken before any update
	always_comb begin
		rd_ent = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (int'(rank) == i) begin
				rd_ent = ents[i];
			end
		end
	end

	assign rank_ok = int'(rank) < int'(count_q);

	always_comb begin
		status_d    = ST_OK;
		ent_d       = '0;
		ent_valid_d = 1'b0;
		case (opcode)
			OP_INSERT: begin
				if (full) begin
					status_d = ST_FULL;
				end
			end
			OP_REMOVE: begin
				if (!found) begin
					status_d = ST_NOT_FOUND;
				end
			end
			OP_READ: begin
				if (!rank_ok) begin
					status_d = ST_BAD_RANK;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
		if (opcode == OP_READ) begin
			if (rank_ok) begin
				ent_d       = rd_ent;
				ent_valid_d = 1'b1;
			end
		end else if (count_d != '0) begin
			// head after the update
			ent_d       = ents_nxt[0];
			ent_valid_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status_d;
			count_out_q <= count_d;
			ent_out_q   <= ent_d;
			ent_valid_q <= ent_valid_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_count = count_out_q;
	assign entry_key   = ent_out_q.key;
	assign entry_tag   = ent_out_q.tag;
	assign entry_valid = ent_valid_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= CAPACITY)
		else $error("fill count above capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_en |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not grow the list");

	a_remove_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rem_en |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("remove did not shrink the list");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == ST_FULL |-> int'(count_out_q) == CAPACITY)
		else $error("full reported below capacity");

	a_bad_rank_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == ST_BAD_RANK |-> !ent_valid_q)
		else $error("entry shown for a rank beyond the count");

endmodule

// ----- bench/sorted_list_checker.sv -----
// checker for the sorted list: mirrors the entries, predicts each result beat and compares it
`timescale 1ns / 100ps
module sorted_list_checker
	import slri_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [1:0]           opcode,
	input  logic [KEY_BITS-1:0]  key,
	input  logic [TAG_BITS-1:0]  tag,
	input  logic [RANK_BITS-1:0] rank,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [1:0]           status,
	input  logic [CNT_W-1:0]     entry_count,
	input  logic [KEY_BITS-1:0]  entry_key,
	input  logic [TAG_BITS-1:0]  entry_tag,
	input  logic                 entry_valid,
	output int                   mismatches,
	output int                   outstanding,
	output int                   results_seen,
	output int                   full_hits,
	output int                   missing_hits,
	output int                   bad_rank_hits
);

	typedef struct packed {
		logic [1:0]       status;
		logic [CNT_W-1:0] count;
		entry_t           ent;
		logic             valid;
	} list_result_t;

	entry_t       mirror [CAPACITY];
	int           held;
	list_result_t expected_q [$];

	initial begin
		mismatches    = 0;
		outstanding   = 0;
		results_seen  = 0;
		full_hits     = 0;
		missing_hits  = 0;
		bad_rank_hits = 0;
		held          = 0;
	end

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	// applies one input beat to the mirror and returns the result it should give
	function automatic list_result_t apply_list_op(logic [1:0] op, entry_t beat,
	                                               logic [RANK_BITS-1:0] pos_rank);
		list_result_t r;
		int pos;
		r = '0;
		r.status = ST_OK;
		case (op)
			OP_INSERT: begin
				if (held >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					// equal keys go after the ones already held
					pos = 0;
					while (pos < held && !(beat.key < mirror[pos].key))
						pos++;
					for (int i = held; i > pos; i--)
						mirror[i] = mirror[i-1];
					mirror[pos] = beat;
					held++;
				end
			end
			OP_REMOVE: begin
				pos = 0;
				while (pos < held && mirror[pos].key != beat.key)
					pos++;
				if (pos >= held) begin
					r.status = ST_NOT_FOUND;
				end else begin
					for (int i = pos; i + 1 < held; i++)
						mirror[i] = mirror[i+1];
					held--;
				end
			end
			default: ;
		endcase
		if (op == OP_READ) begin
			if (int'(pos_rank) >= held) begin
				r.status = ST_BAD_RANK;
			end else begin
				r.ent   = mirror[pos_rank];
				r.valid = 1'b1;
			end
		end else if (held > 0) begin
			r.ent   = mirror[0];
			r.valid = 1'b1;
		end
		r.count = CNT_W'(held);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		list_result_t want;
		if (!arst_n) begin
			held = 0;
			expected_q.delete();
			outstanding <= 0;
		end else begin
			// push first so a result given in the same cycle as its beat would still find its expectation
			if (in_valid && !in_stall)
				expected_q.push_back(apply_list_op(opcode, entry_t'({key, tag}), rank));
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					report_mismatch("result beat with nothing expected", 32'(status), 32'd0);
				end else begin
					want = expected_q.pop_front();
					results_seen++;
					case (want.status)
						ST_FULL:      full_hits++;
						ST_NOT_FOUND: missing_hits++;
						ST_BAD_RANK:  bad_rank_hits++;
						default: ;
					endcase
					if (status !== want.status)
						report_mismatch("status", 32'(status), 32'(want.status));
					if (entry_count !== want.count)
						report_mismatch("entry_count", 32'(entry_count), 32'(want.count));
					if (entry_key !== want.ent.key)
						report_mismatch("entry_key", 32'(entry_key), 32'(want.ent.key));
					if (entry_tag !== want.ent.tag)
						report_mismatch("entry_tag", 32'(entry_tag), 32'(want.ent.tag));
					if (entry_valid !== want.valid)
						report_mismatch("entry_valid", 32'(entry_valid), 32'(want.valid));
				end
			end
			outstanding <= expected_q.size();
		end
	end

endmodule

// ----- bench/tb_top.sv -----
// testbench top: drives the sorted list with directed and random beats and gives the verdict
`timescale 1ns / 100ps
module tb_top;
	import slri_pkg::*;

	localparam logic [1:0] OP_SPARE    = 2'd3;
	localparam int         PHASE_BEATS = 450;
	localparam int         BIAS_RUN    = 60;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 in_valid    = 1'b0;
	logic                 in_stall;
	logic [1:0]           opcode      = OP_READ;
	logic [KEY_BITS-1:0]  key         = '0;
	logic [TAG_BITS-1:0]  tag         = '0;
	logic [RANK_BITS-1:0] rank        = '0;
	logic                 out_valid;
	logic                 out_stall   = 1'b0;
	logic [1:0]           status;
	logic [CNT_W-1:0]     entry_count;
	logic [KEY_BITS-1:0]  entry_key;
	logic [TAG_BITS-1:0]  entry_tag;
	logic                 entry_valid;

	int mismatches;
	int outstanding;
	int results_seen;
	int full_hits;
	int missing_hits;
	int bad_rank_hits;
	int idle_pct  = 0;
	int stall_pct = 0;
	int beats_sent = 0;

	sorted_list_insert_remove i_dut (.*);

	sorted_list_checker i_checker (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("CHECKS FAILED");
		$finish;
	end

	always @(posedge clk)
		out_stall <= ($urandom_range(0, 99) < stall_pct);

	task automatic send_beat(logic [1:0] op, logic [KEY_BITS-1:0] k,
	                         logic [TAG_BITS-1:0] t, logic [RANK_BITS-1:0] r);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		key      <= k;
		tag      <= t;
		rank     <= r;
		do @(posedge clk); while (in_stall);
		beats_sent++;
	endtask

	// mostly keys from a small set so that removes hit and duplicates occur
	function automatic logic [KEY_BITS-1:0] pick_key();
		logic [3:0] nib;
		nib = 4'($urandom_range(0, 15));
		if ($urandom_range(0, 3) != 0)
			return {(KEY_BITS/4){nib}};
		return KEY_BITS'($urandom);
	endfunction

	task automatic send_random_beat(bit filling);
		int roll;
		logic [1:0] op;
		roll = $urandom_range(0, 99);
		if (filling)
			op = (roll < 65) ? OP_INSERT : (roll < 85) ? OP_REMOVE :
			     (roll < 98) ? OP_READ : OP_SPARE;
		else
			op = (roll < 25) ? OP_INSERT : (roll < 80) ? OP_REMOVE :
			     (roll < 98) ? OP_READ : OP_SPARE;
		send_beat(op, pick_key(), TAG_BITS'($urandom), RANK_BITS'($urandom_range(0, 15)));
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		stall_pct <= 30;
		send_beat(OP_READ,   16'h0000, 8'h00, 4'd0);   // read on an empty list
		send_beat(OP_REMOVE, 16'h0000, 8'h00, 4'd0);   // remove on an empty list
		send_beat(OP_INSERT, 16'h8000, 8'h11, 4'd0);
		send_beat(OP_INSERT, 16'h0000, 8'h00, 4'd0);
		send_beat(OP_INSERT, 16'hffff, 8'hff, 4'd0);
		send_beat(OP_INSERT, 16'h8000, 8'h22, 4'd0);   // equal key keeps arrival order
		send_beat(OP_READ,   16'h0000, 8'h00, 4'd2);
		send_beat(OP_READ,   16'h0000, 8'h00, 4'd3);
		send_beat(OP_READ,   16'h0000, 8'h00, 4'd4);
		send_beat(OP_READ,   16'hffff, 8'hff, 4'd15);  // rank past the count
		send_beat(OP_REMOVE, 16'h8000, 8'h00, 4'd0);   // removes the first of the pair
		send_beat(OP_READ,   16'h0000, 8'h00, 4'd1);
		send_beat(OP_REMOVE, 16'h1234, 8'h00, 4'd0);   // key not held
		send_beat(OP_SPARE,  16'hffff, 8'hff, 4'd15);  // unused opcode
		send_beat(OP_INSERT, 16'h8000, 8'h33, 4'd0);   // reuses the freed slot
		send_beat(OP_READ,   16'h0000, 8'h00, 4'd2);
		send_beat(OP_REMOVE, 16'h0000, 8'h00, 4'd0);
		send_beat(OP_REMOVE, 16'hffff, 8'h00, 4'd0);
		send_beat(OP_REMOVE, 16'h8000, 8'h00, 4'd0);
		send_beat(OP_REMOVE, 16'h8000, 8'h00, 4'd0);   // list empty after remove
		send_beat(OP_READ,   16'h0000, 8'h00, 4'd0);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct <= 0;  end
				1: begin idle_pct = 86; stall_pct <= 0;  end
				2: begin idle_pct = 0;  stall_pct <= 86; end
				default: begin idle_pct = 10; stall_pct <= 10; end
			endcase
			// alternate runs that fill the list and runs that drain it
			for (int n = 0; n < PHASE_BEATS; n++)
				send_random_beat(((n / BIAS_RUN) % 2) == 0);
		end
		in_valid <= 1'b0;

		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);

		$display("sent %0d beats over four idling phases, %0d results checked",
		         beats_sent, results_seen);
		$display("status seen: list full %0d, key missing %0d, rank past count %0d",
		         full_hits, missing_hits, bad_rank_hits);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- sorted_list_insert_remove.f -----
hw/rtl/slri_pkg.sv
hw/rtl/slri_cell.sv
hw/rtl/sorted_list_insert_remove.sv
bench/sorted_list_checker.sv
bench/tb_top.sv
